[rtl/core/svg_pkg.sv]
// shared types, constants and helper functions of the state vector gate engine
package svg_pkg;

    localparam int MAX_QUBITS = 10;
    localparam int AMP_WIDTH  = 18;

    localparam int VEC_AW   = MAX_QUBITS;
    localparam int VEC_DEPTH = 1 << MAX_QUBITS;
    localparam int SUM_W    = AMP_WIDTH + 1;
    localparam int COEF_W   = 30;
    localparam int PROD_W   = SUM_W + COEF_W;
    localparam int QC_W     = 4;
    localparam int OUT_W    = 18;
    localparam int STAT_W   = 2;

    localparam logic [COEF_W-1:0] INV_SQRT2_Q30 = COEF_W'(759250125);
    localparam logic [PROD_W-1:0] ROUND_HALF    = PROD_W'(1) << (COEF_W - 1);

    typedef logic signed [AMP_WIDTH-1:0] amp_t;
    typedef logic signed [SUM_W-1:0]     sum_t;
    typedef logic signed [SUM_W:0]       wide_t;
    typedef logic [OUT_W-1:0]            out_amp_t;

    localparam amp_t AMP_ONE = amp_t'(1) <<< (AMP_WIDTH - 2);

    typedef enum logic [2:0] {
        FN_RESET  = 3'd0,
        FN_HADAM  = 3'd1,
        FN_PAULIX = 3'd2,
        FN_PAULIZ = 3'd3,
        FN_CNOT   = 3'd4,
        FN_READ   = 3'd5
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_BAD     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BF_HADAM  = 2'd0,
        BF_SWAP   = 2'd1,
        BF_NEGATE = 2'd2,
        BF_KEEP   = 2'd3
    } bf_op_t;

    typedef struct packed {
        logic   ld_a0;
        logic   ld_a1;
        logic   ld_prod;
        bf_op_t op;
    } bf_ctrl_t;

    function automatic amp_t sat_amp(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = {3'b000, {(AMP_WIDTH-1){1'b1}}};
        lo = {3'b111, {(AMP_WIDTH-1){1'b0}}};
        if (v > hi) begin
            return amp_t'(hi);
        end else if (v < lo) begin
            return amp_t'(lo);
        end
        return amp_t'(v);
    endfunction

    // low output bits of the sign-extended amplitude
    function automatic out_amp_t to_out(amp_t a);
        logic signed [63:0] w;
        w = 64'(a);
        return w[OUT_W-1:0];
    endfunction

endpackage

[rtl/core/state_vector_gate_engine.sv]
// top level: operation sequencer, amplitude stores and result register
// Each accepted operation gives one result. After reset the block clears its stores with
// s_tready low, writing all 2^MAX_QUBITS entries; a reset operation takes the same sweep.
// A one-qubit gate or CNOT walks the 2^(n-1) amplitude pairs one at a time, each through
// RD0, RD1, SUM, MUL, WR0 and WR1 (two reads and two writes through the single read and
// single write port of each store, plus the add and multiply stages). A read passes through
// RDA and RDB; a rejected operation is answered from idle. A new operation is taken only
// while the output register is empty or its result transfers in that same cycle.
module state_vector_gate_engine (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // func[2:0], qubit_a[6:3], qubit_b[10:7], second_given[11], read_index[21:12]
    input  logic [23:0]              s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // amp_real[17:0], amp_imag[35:18], status[37:36]
    output logic [39:0]              m_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [svg_pkg::QC_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_RD1,
        S_SUM,
        S_MUL,
        S_WR0,
        S_WR1,
        S_RDA,
        S_RDB
    } state_t;

    localparam int AW = svg_pkg::VEC_AW;

    state_t                  state_reg,    state_next;
    logic [AW-1:0]           cnt_reg,      cnt_next;
    logic                    clr_op_reg,   clr_op_next;
    logic [svg_pkg::QC_W-1:0] q_reg,       q_next;
    logic [svg_pkg::QC_W-1:0] ctl_reg,     ctl_next;
    logic                    cnot_reg,     cnot_next;
    svg_pkg::bf_op_t         op_reg,       op_next;
    logic [AW-1:0]           ridx_reg,     ridx_next;
    logic [svg_pkg::QC_W-1:0] qc_reg,      qc_next;
    logic                    m_valid_reg,  m_valid_next;
    svg_pkg::out_amp_t       m_real_reg,   m_real_next;
    svg_pkg::out_amp_t       m_imag_reg,   m_imag_next;
    svg_pkg::status_t        m_status_reg, m_status_next;

    logic [2:0]               in_func;
    logic [svg_pkg::QC_W-1:0] in_qa;
    logic [svg_pkg::QC_W-1:0] in_qb;
    logic                     in_second;
    logic [9:0]               in_ridx;
    logic                     s_xfer;

    logic [svg_pkg::QC_W:0] n_eff;
    logic [AW:0]            pair_span;
    logic [AW-1:0]          pair_last;
    logic [AW-1:0]          tbit;
    logic [AW-1:0]          lowm;
    logic [AW-1:0]          cbit;
    logic [AW-1:0]          addr_i;
    logic [AW-1:0]          addr_j;
    logic                   ridx_bad;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    svg_pkg::amp_t          ram_wre;
    svg_pkg::amp_t          ram_wim;
    svg_pkg::amp_t          re_rdata;
    svg_pkg::amp_t          im_rdata;
    svg_pkg::amp_t          re_out0, re_out1, im_out0, im_out1;
    svg_pkg::bf_ctrl_t      bf_ctrl;

    logic                   fin;
    svg_pkg::status_t       fin_status;
    svg_pkg::out_amp_t      fin_re;
    svg_pkg::out_amp_t      fin_im;

    assign in_func   = s_tdata[2:0];
    assign in_qa     = s_tdata[6:3];
    assign in_qb     = s_tdata[10:7];
    assign in_second = s_tdata[11];
    assign in_ridx   = s_tdata[21:12];

    assign s_tready  = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_status_reg, m_imag_reg, m_real_reg};

    // qubit count above the store size acts as the store size
    assign n_eff = (qc_reg > svg_pkg::QC_W'(svg_pkg::MAX_QUBITS))
                 ? (svg_pkg::QC_W+1)'(svg_pkg::MAX_QUBITS)
                 : {1'b0, qc_reg};
    assign pair_span = (AW+1)'(1) << (n_eff - (svg_pkg::QC_W+1)'(1));
    assign pair_last = AW'(pair_span - (AW+1)'(1));
    assign ridx_bad  = (32'(in_ridx) >> n_eff) != 32'd0;

    // pair index with a zero bit inserted at the target position
    assign tbit   = AW'(1) << q_reg;
    assign lowm   = tbit - AW'(1);
    assign cbit   = AW'(1) << ctl_reg;
    assign addr_i = AW'((cnt_reg & ~lowm) << 1) | (cnt_reg & lowm);
    assign addr_j = addr_i | tbit;

    always_comb begin
        bf_ctrl.ld_a0   = (state_reg == S_RD1);
        bf_ctrl.ld_a1   = (state_reg == S_SUM);
        bf_ctrl.ld_prod = (state_reg == S_MUL);
        bf_ctrl.op      = (cnot_reg && ((addr_i & cbit) == '0)) ? svg_pkg::BF_KEEP : op_reg;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_i;
        ram_raddr = addr_i;
        ram_wre   = re_out0;
        ram_wim   = im_out0;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wre   = (cnt_reg == '0) ? svg_pkg::AMP_ONE : '0;
                ram_wim   = '0;
            end
            S_RD1: begin
                ram_raddr = addr_j;
            end
            S_RDA: begin
                ram_raddr = ridx_reg;
            end
            S_WR0: begin
                ram_we = 1'b1;
            end
            S_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = addr_j;
                ram_wre   = re_out1;
                ram_wim   = im_out1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        clr_op_next   = clr_op_reg;
        q_next        = q_reg;
        ctl_next      = ctl_reg;
        cnot_next     = cnot_reg;
        op_next       = op_reg;
        ridx_next     = ridx_reg;
        qc_next       = qc_reg;
        fin           = 1'b0;
        fin_status    = svg_pkg::STAT_DONE;
        fin_re        = '0;
        fin_im        = '0;

        if (cfg_valid && cfg_ready) begin
            qc_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR: begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == '1) begin
                    state_next  = S_IDLE;
                    clr_op_next = 1'b0;
                    fin         = clr_op_reg;
                end
            end
            S_IDLE: begin
                if (s_xfer) begin
                    cnt_next = '0;
                    case (in_func)
                        svg_pkg::FN_RESET: begin
                            state_next  = S_CLEAR;
                            clr_op_next = 1'b1;
                        end
                        svg_pkg::FN_HADAM, svg_pkg::FN_PAULIX, svg_pkg::FN_PAULIZ: begin
                            if ({1'b0, in_qa} >= n_eff) begin
                                fin        = 1'b1;
                                fin_status = svg_pkg::STAT_BAD;
                            end else begin
                                state_next = S_RD0;
                                q_next     = in_qa;
                                cnot_next  = 1'b0;
                                if (in_func == svg_pkg::FN_HADAM) begin
                                    op_next = svg_pkg::BF_HADAM;
                                end else if (in_func == svg_pkg::FN_PAULIX) begin
                                    op_next = svg_pkg::BF_SWAP;
                                end else begin
                                    op_next = svg_pkg::BF_NEGATE;
                                end
                            end
                        end
                        svg_pkg::FN_CNOT: begin
                            if (!in_second || ({1'b0, in_qa} >= n_eff) ||
                                ({1'b0, in_qb} >= n_eff) || (in_qa == in_qb)) begin
                                fin        = 1'b1;
                                fin_status = svg_pkg::STAT_BAD;
                            end else begin
                                state_next = S_RD0;
                                q_next     = in_qb;
                                ctl_next   = in_qa;
                                cnot_next  = 1'b1;
                                op_next    = svg_pkg::BF_SWAP;
                            end
                        end
                        svg_pkg::FN_READ: begin
                            if (ridx_bad) begin
                                fin        = 1'b1;
                                fin_status = svg_pkg::STAT_BAD;
                            end else begin
                                state_next = S_RDA;
                                ridx_next  = AW'(in_ridx);
                            end
                        end
                        default: begin
                            fin        = 1'b1;
                            fin_status = svg_pkg::STAT_UNKNOWN;
                        end
                    endcase
                end
            end
            S_RD0: state_next = S_RD1;
            S_RD1: state_next = S_SUM;
            S_SUM: state_next = S_MUL;
            S_MUL: state_next = S_WR0;
            S_WR0: state_next = S_WR1;
            S_WR1: begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == pair_last) begin
                    state_next = S_IDLE;
                    fin        = 1'b1;
                end else begin
                    state_next = S_RD0;
                end
            end
            S_RDA: state_next = S_RDB;
            S_RDB: begin
                state_next = S_IDLE;
                fin        = 1'b1;
                fin_re     = svg_pkg::to_out(re_rdata);
                fin_im     = svg_pkg::to_out(im_rdata);
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_real_next   = m_real_reg;
        m_imag_next   = m_imag_reg;
        m_status_next = m_status_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (fin) begin
            m_valid_next  = 1'b1;
            m_real_next   = fin_re;
            m_imag_next   = fin_im;
            m_status_next = fin_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            clr_op_reg  <= 1'b0;
            cnot_reg    <= 1'b0;
            qc_reg      <= svg_pkg::QC_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            clr_op_reg  <= clr_op_next;
            cnot_reg    <= cnot_next;
            qc_reg      <= qc_next;
            m_valid_reg <= m_valid_next;
        end
        q_reg        <= q_next;
        ctl_reg      <= ctl_next;
        op_reg       <= op_next;
        ridx_reg     <= ridx_next;
        m_real_reg   <= m_real_next;
        m_imag_reg   <= m_imag_next;
        m_status_reg <= m_status_next;
    end

    svg_ram #(
        .WIDTH (svg_pkg::AMP_WIDTH),
        .DEPTH (svg_pkg::VEC_DEPTH)
    ) u_re_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wre),
        .raddr (ram_raddr),
        .rdata (re_rdata)
    );

    svg_ram #(
        .WIDTH (svg_pkg::AMP_WIDTH),
        .DEPTH (svg_pkg::VEC_DEPTH)
    ) u_im_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wim),
        .raddr (ram_raddr),
        .rdata (im_rdata)
    );

    svg_butterfly u_re_bf (
        .aclk  (aclk),
        .ctrl  (bf_ctrl),
        .rdata (re_rdata),
        .out0  (re_out0),
        .out1  (re_out1)
    );

    svg_butterfly u_im_bf (
        .aclk  (aclk),
        .ctrl  (bf_ctrl),
        .rdata (im_rdata),
        .out0  (im_out0),
        .out1  (im_out1)
    );

`ifndef SYNTHESIS
    // a finished result never lands on one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        fin |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_status_reg != svg_pkg::STAT_DONE)) |->
        ((m_real_reg == '0) && (m_imag_reg == '0)))
        else $error("error result carries amplitude data");

    a_reset_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (in_func == svg_pkg::FN_RESET)) |=> (state_reg == S_CLEAR))
        else $error("reset operation did not start clear sweep");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR0) |=> ((state_reg == S_WR1) && $stable(cnt_reg)))
        else $error("pair write-back split");

    a_pair_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR0) |-> ((addr_i & tbit) == '0))
        else $error("low pair address has target bit set");
`endif

endmodule

[rtl/core/svg_ram.sv]
// generic simple dual-port ram with registered read
module svg_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/svg_butterfly.sv]
// pair datapath for one component: hadamard butterfly, swap, negate or keep
module svg_butterfly (
    input  logic              aclk,
    input  svg_pkg::bf_ctrl_t ctrl,
    input  svg_pkg::amp_t     rdata,
    output svg_pkg::amp_t     out0,
    output svg_pkg::amp_t     out1
);

    svg_pkg::amp_t a0_reg;
    svg_pkg::amp_t a1_reg;
    svg_pkg::sum_t sum_reg;
    svg_pkg::sum_t diff_reg;
    logic [svg_pkg::PROD_W-1:0] prod0_reg;
    logic [svg_pkg::PROD_W-1:0] prod1_reg;
    logic neg0_reg;
    logic neg1_reg;

    logic [svg_pkg::SUM_W-1:0] mag0;
    logic [svg_pkg::SUM_W-1:0] mag1;
    logic [svg_pkg::PROD_W-1:0] rnd0;
    logic [svg_pkg::PROD_W-1:0] rnd1;
    svg_pkg::wide_t hv0;
    svg_pkg::wide_t hv1;
    svg_pkg::wide_t nv1;
    svg_pkg::amp_t h0;
    svg_pkg::amp_t h1;
    svg_pkg::amp_t z1;

    assign mag0 = sum_reg[svg_pkg::SUM_W-1]  ? svg_pkg::SUM_W'(-sum_reg)  : sum_reg;
    assign mag1 = diff_reg[svg_pkg::SUM_W-1] ? svg_pkg::SUM_W'(-diff_reg) : diff_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.ld_a0) begin
            a0_reg <= rdata;
        end
        if (ctrl.ld_a1) begin
            a1_reg   <= rdata;
            sum_reg  <= svg_pkg::SUM_W'(a0_reg) + svg_pkg::SUM_W'(rdata);
            diff_reg <= svg_pkg::SUM_W'(a0_reg) - svg_pkg::SUM_W'(rdata);
        end
        if (ctrl.ld_prod) begin
            prod0_reg <= svg_pkg::PROD_W'(mag0) * svg_pkg::PROD_W'(svg_pkg::INV_SQRT2_Q30);
            prod1_reg <= svg_pkg::PROD_W'(mag1) * svg_pkg::PROD_W'(svg_pkg::INV_SQRT2_Q30);
            neg0_reg  <= sum_reg[svg_pkg::SUM_W-1];
            neg1_reg  <= diff_reg[svg_pkg::SUM_W-1];
        end
    end

    // round half away from zero on the magnitude, then restore sign and saturate
    assign rnd0 = prod0_reg + svg_pkg::ROUND_HALF;
    assign rnd1 = prod1_reg + svg_pkg::ROUND_HALF;
    assign hv0  = neg0_reg ? -svg_pkg::wide_t'({1'b0, rnd0[svg_pkg::PROD_W-1:svg_pkg::COEF_W]})
                           :  svg_pkg::wide_t'({1'b0, rnd0[svg_pkg::PROD_W-1:svg_pkg::COEF_W]});
    assign hv1  = neg1_reg ? -svg_pkg::wide_t'({1'b0, rnd1[svg_pkg::PROD_W-1:svg_pkg::COEF_W]})
                           :  svg_pkg::wide_t'({1'b0, rnd1[svg_pkg::PROD_W-1:svg_pkg::COEF_W]});
    assign nv1  = -svg_pkg::wide_t'(a1_reg);
    assign h0   = svg_pkg::sat_amp(hv0);
    assign h1   = svg_pkg::sat_amp(hv1);
    assign z1   = svg_pkg::sat_amp(nv1);

    always_comb begin
        case (ctrl.op)
            svg_pkg::BF_HADAM: begin
                out0 = h0;
                out1 = h1;
            end
            svg_pkg::BF_SWAP: begin
                out0 = a1_reg;
                out1 = a0_reg;
            end
            svg_pkg::BF_NEGATE: begin
                out0 = a0_reg;
                out1 = z1;
            end
            default: begin
                out0 = a0_reg;
                out1 = a1_reg;
            end
        endcase
    end

endmodule

[tb/svg_result_checker.sv]
// result checker: tracks the state vector, predicts each result and compares every result transfer
module svg_result_checker (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [23:0]              s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [39:0]              m_tdata,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [svg_pkg::QC_W-1:0] cfg_data,
    output int                       outstanding,
    output int                       mismatches
);

    localparam longint AMP_HI = (longint'(1) << (svg_pkg::AMP_WIDTH - 1)) - 1;
    localparam longint AMP_LO = -(longint'(1) << (svg_pkg::AMP_WIDTH - 1));

    typedef struct packed {
        svg_pkg::out_amp_t re;
        svg_pkg::out_amp_t im;
        svg_pkg::status_t  st;
    } amp_result_t;

    svg_pkg::amp_t            re_amp [svg_pkg::VEC_DEPTH];
    svg_pkg::amp_t            im_amp [svg_pkg::VEC_DEPTH];
    logic [svg_pkg::QC_W-1:0] qubit_reg;
    amp_result_t              expected_results [$];
    int                       results_seen;

    function automatic svg_pkg::amp_t clip(longint v);
        if (v > AMP_HI) begin
            return svg_pkg::amp_t'(AMP_HI);
        end
        if (v < AMP_LO) begin
            return svg_pkg::amp_t'(AMP_LO);
        end
        return svg_pkg::amp_t'(v);
    endfunction

    // multiply by 1/sqrt(2) in q30, round half away from zero, then clip
    function automatic svg_pkg::amp_t scale_half_root(longint s);
        longint mag;
        longint r;
        mag = (s < 0) ? -s : s;
        r = (mag * longint'(svg_pkg::INV_SQRT2_Q30) + (longint'(1) << 29)) >>> 30;
        return clip((s < 0) ? -r : r);
    endfunction

    function automatic void clear_vector();
        for (int i = 0; i < svg_pkg::VEC_DEPTH; i++) begin
            re_amp[i] = '0;
            im_amp[i] = '0;
        end
        re_amp[0] = svg_pkg::AMP_ONE;
    endfunction

    function automatic void swap_pair(int a, int b);
        svg_pkg::amp_t t;
        t = re_amp[a];
        re_amp[a] = re_amp[b];
        re_amp[b] = t;
        t = im_amp[a];
        im_amp[a] = im_amp[b];
        im_amp[b] = t;
    endfunction

    function automatic amp_result_t apply_operation(logic [23:0] word);
        logic [2:0]  fn;
        logic [3:0]  qa;
        logic [3:0]  qb;
        logic        second;
        logic [9:0]  ridx;
        int          n;
        int          dim;
        int          abit;
        int          bbit;
        int          j;
        longint      p0;
        longint      p1;
        amp_result_t res;
        fn     = word[2:0];
        qa     = word[6:3];
        qb     = word[10:7];
        second = word[11];
        ridx   = word[21:12];
        n      = (int'(qubit_reg) > svg_pkg::MAX_QUBITS) ? svg_pkg::MAX_QUBITS
                                                         : int'(qubit_reg);
        dim    = 1 << n;
        abit   = 1 << qa;
        bbit   = 1 << qb;
        res.re = '0;
        res.im = '0;
        res.st = svg_pkg::STAT_DONE;
        case (fn)
            svg_pkg::FN_RESET: begin
                clear_vector();
            end
            svg_pkg::FN_HADAM, svg_pkg::FN_PAULIX, svg_pkg::FN_PAULIZ: begin
                if (int'(qa) >= n) begin
                    res.st = svg_pkg::STAT_BAD;
                end else begin
                    for (int i = 0; i < dim; i++) begin
                        if ((i & abit) == 0) begin
                            j = i | abit;
                            if (fn == svg_pkg::FN_HADAM) begin
                                p0 = re_amp[i];
                                p1 = re_amp[j];
                                re_amp[i] = scale_half_root(p0 + p1);
                                re_amp[j] = scale_half_root(p0 - p1);
                                p0 = im_amp[i];
                                p1 = im_amp[j];
                                im_amp[i] = scale_half_root(p0 + p1);
                                im_amp[j] = scale_half_root(p0 - p1);
                            end else if (fn == svg_pkg::FN_PAULIX) begin
                                swap_pair(i, j);
                            end else begin
                                re_amp[j] = clip(-longint'(re_amp[j]));
                                im_amp[j] = clip(-longint'(im_amp[j]));
                            end
                        end
                    end
                end
            end
            svg_pkg::FN_CNOT: begin
                if (!second || int'(qa) >= n || int'(qb) >= n || qa == qb) begin
                    res.st = svg_pkg::STAT_BAD;
                end else begin
                    for (int i = 0; i < dim; i++) begin
                        if ((i & abit) != 0 && (i & bbit) == 0) begin
                            swap_pair(i, i | bbit);
                        end
                    end
                end
            end
            svg_pkg::FN_READ: begin
                if (int'(ridx) >= dim) begin
                    res.st = svg_pkg::STAT_BAD;
                end else begin
                    res.re = re_amp[ridx];
                    res.im = im_amp[ridx];
                end
            end
            default: begin
                res.st = svg_pkg::STAT_UNKNOWN;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("svg_result_checker: result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_result(logic [39:0] word);
        amp_result_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch("transfer with no operation pending");
            return;
        end
        want = expected_results.pop_front();
        if (word[17:0] != want.re) begin
            report_mismatch($sformatf("amp_real %0d, want %0d",
                                      $signed(word[17:0]), $signed(want.re)));
        end
        if (word[35:18] != want.im) begin
            report_mismatch($sformatf("amp_imag %0d, want %0d",
                                      $signed(word[35:18]), $signed(want.im)));
        end
        if (word[37:36] != want.st) begin
            report_mismatch($sformatf("status %0d, want %0d", word[37:36], want.st));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            qubit_reg = 4'd1;
            clear_vector();
            expected_results.delete();
            results_seen = 0;
            mismatches = 0;
        end else begin
            // results leave before the operation taken at this same edge is queued
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
            if (cfg_valid && cfg_ready) begin
                qubit_reg = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_operation(s_tdata));
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

[tb/state_vector_gate_engine_test.sv]
// testbench top: clock, reset, operation stimulus, config writes and verdict
module state_vector_gate_engine_test;

    localparam logic [2:0] FN_ILLEGAL_LO = 3'd6;
    localparam logic [2:0] FN_ILLEGAL_HI = 3'd7;
    // gates at ten qubits dominate the run time
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 16;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [23:0]              s_tdata;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [39:0]              m_tdata;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [svg_pkg::QC_W-1:0] cfg_data;

    int                       outstanding;
    int                       mismatches;
    int                       send_idle_pct;
    int                       recv_idle_pct;
    int                       cycle_count = 0;
    logic [svg_pkg::QC_W-1:0] qubit_setting;

    always #2 aclk = ~aclk;

    state_vector_gate_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    svg_result_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("state_vector_gate_engine_test: done, errors");
            $finish;
        end
    end

    // func[2:0], qubit_a[6:3], qubit_b[10:7], second_given[11], read_index[21:12]
    function automatic logic [23:0] pack_op(logic [2:0] fn, logic [3:0] qa, logic [3:0] qb,
                                            logic second, logic [9:0] ridx);
        return {2'b00, ridx, second, qb, qa, fn};
    endfunction

    task automatic send_op(logic [23:0] word);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_results_in();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic set_qubits(logic [svg_pkg::QC_W-1:0] count);
        wait_results_in();
        qubit_setting = count;
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly legal gates and reads on the active qubits, the rest raw noise
    task automatic random_op();
        int         n;
        int         pick;
        logic [2:0] fn;
        logic [3:0] qa;
        logic [3:0] qb;
        logic       second;
        logic [9:0] ridx;
        n      = (int'(qubit_setting) > svg_pkg::MAX_QUBITS) ? svg_pkg::MAX_QUBITS
                                                             : int'(qubit_setting);
        fn     = 3'($urandom);
        qa     = 4'($urandom);
        qb     = 4'($urandom);
        second = 1'($urandom);
        ridx   = 10'($urandom);
        if (n > 0 && $urandom_range(99) < 82) begin
            second = 1'b1;
            qa     = 4'($urandom_range(n - 1));
            pick   = $urandom_range(99);
            if (pick < 2) begin
                fn = svg_pkg::FN_RESET;
            end else if (pick < 36) begin
                fn   = svg_pkg::FN_READ;
                ridx = 10'($urandom_range((1 << n) - 1));
            end else if (pick < 60) begin
                fn = svg_pkg::FN_HADAM;
            end else if (pick < 72) begin
                fn = svg_pkg::FN_PAULIX;
            end else if (pick < 84) begin
                fn = svg_pkg::FN_PAULIZ;
            end else if (n > 1) begin
                fn = svg_pkg::FN_CNOT;
                qb = 4'($urandom_range(n - 2));
                if (qb >= qa) begin
                    qb++;
                end
            end else begin
                fn = svg_pkg::FN_HADAM;
            end
        end else if (n == 0 && $urandom_range(1) == 1) begin
            fn   = svg_pkg::FN_READ;
            ridx = '0;
        end
        send_op(pack_op(fn, qa, qb, second, ridx));
    endtask

    initial begin
        logic [svg_pkg::QC_W-1:0] phase_counts [9] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd15,
                                                       4'd5, 4'd10, 4'd2};
        int              n;
        int              items;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        qubit_setting = 4'd1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // one qubit out of reset
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd1));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd2));
        send_op(pack_op(svg_pkg::FN_HADAM, 4'd0, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd1));
        send_op(pack_op(svg_pkg::FN_HADAM, 4'd1, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(FN_ILLEGAL_LO, 4'd0, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(FN_ILLEGAL_HI, 4'hf, 4'hf, 1'b1, 10'h3ff));

        set_qubits(4'd3);
        send_op(pack_op(svg_pkg::FN_PAULIX, 4'd2, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_PAULIZ, 4'd0, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_CNOT, 4'd0, 4'd1, 1'b1, 10'd0));
        // missing target, equal control and target, target out of range
        send_op(pack_op(svg_pkg::FN_CNOT, 4'd0, 4'd1, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_CNOT, 4'd2, 4'd2, 1'b1, 10'd0));
        send_op(pack_op(svg_pkg::FN_CNOT, 4'd1, 4'hf, 1'b1, 10'd0));
        send_op(pack_op(svg_pkg::FN_HADAM, 4'hf, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'h3ff));
        send_op(pack_op(svg_pkg::FN_HADAM, 4'd2, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd5));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd6));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd3));
        send_op(pack_op(svg_pkg::FN_RESET, 4'd0, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd0));
        send_op(pack_op(svg_pkg::FN_READ, 4'd0, 4'd0, 1'b0, 10'd4));

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 52 : 0;
            recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 12 : 0;
            foreach (phase_counts[p]) begin
                set_qubits(phase_counts[p]);
                n = (int'(phase_counts[p]) > svg_pkg::MAX_QUBITS) ? svg_pkg::MAX_QUBITS
                                                                  : int'(phase_counts[p]);
                // full-width gates are slow, so few items there
                items = (n == 0) ? 12 : (n >= svg_pkg::MAX_QUBITS) ? 8 : (n > 4) ? 20 : 28;
                repeat (items) random_op();
            end
        end

        wait_results_in();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("state_vector_gate_engine_test: done, clean");
        end else begin
            $display("state_vector_gate_engine_test: done, errors");
        end
        $finish;
    end

endmodule
